[rtl/tcte_pkg.sv]
// Shared types and constants of the text terminal character engine.
// Used by the front, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcte_pkg;

  localparam logic [7:0]  GridLimit  = 8'd255;
  localparam logic [7:0]  ResetCols  = 8'd80;
  localparam logic [7:0]  ResetRows  = 8'd25;
  localparam logic [7:0]  ResetAttr  = 8'd10;
  localparam logic [7:0]  ChSpace    = 8'h20;
  localparam logic [16:0] NumCap     = 17'd10000;

  typedef enum logic [2:0] {
    CMD_GLYPH  = 3'd0,
    CMD_SCROLL = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_CURSOR = 3'd4
  } tcte_cmd_e;

  typedef enum logic [3:0] {
    OP_PUT,
    OP_BS,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_LEFT,
    OP_HOME,
    OP_CLEAR,
    OP_ERASE
  } tcte_op_e;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_COLS   = 2'd1,
    REG_ROWS   = 2'd2,
    REG_ATTR   = 2'd3
  } tcte_reg_e;

  typedef struct packed {
    tcte_op_e    op;
    logic [16:0] arg;
  } tcte_op_t;

endpackage

`default_nettype wire

[rtl/text_terminal_char_engine.sv]
// Top level of the text terminal character engine: configuration registers,
// front parser with its queue, and back command sequencer.
// Depends on tcte_pkg, tcte_front and tcte_back.
`timescale 1ns / 1ps
`default_nettype none

// Each character byte pushed in produces up to six display commands, which
// leave at most one per cycle through a single result register while the
// receiver keeps popping. The parser classifies each byte combinationally
// and registers its operation into the queue; the back part then takes the
// operation, steps through one state per command and one more for a line
// advance, and for a cursor-left whose move crosses a row runs the eight
// steps of the bit-serial row/column divider. The two-entry queue between
// parser and sequencer lets bytes that yield no command, such as escape
// prefixes and digits, be taken while commands are still draining.

module text_terminal_char_engine import tcte_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_code_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      command_o,
  output logic [7:0]      glyph_o,
  output logic [7:0]      attribute_o,
  output logic [7:0]      pos_x_o,
  output logic [7:0]      pos_y_o,
  output logic            last_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic       enable_q;
  logic [7:0] cols_q, rows_q, attr_q;
  logic [7:0] eff_cols, eff_rows;
  logic       op_valid, op_pop;
  tcte_op_t   op;

  assign cfg_ready_o = 1'b1;
  assign eff_cols    = (cols_q > GridLimit) ? GridLimit : cols_q;
  assign eff_rows    = (rows_q > GridLimit) ? GridLimit : rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      cols_q   <= ResetCols;
      rows_q   <= ResetRows;
      attr_q   <= ResetAttr;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tcte_reg_e'(cfg_index_i))
        REG_ENABLE: enable_q <= cfg_data_i[0];
        REG_COLS:   cols_q   <= cfg_data_i;
        REG_ROWS:   rows_q   <= cfg_data_i;
        REG_ATTR:   attr_q   <= cfg_data_i;
        default:    enable_q <= enable_q;
      endcase
    end else if (push && !full && enable_q && (cols_q == 8'd0 || rows_q == 8'd0)) begin
      cols_q <= ResetCols;
      rows_q <= ResetRows;
    end
  end

  tcte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .char_i     (char_code_i),
    .enable_i   (enable_q),
    .full_o     (full),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  tcte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .cols_i      (eff_cols),
    .rows_i      (eff_rows),
    .attr_i      (attr_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .command_o   (command_o),
    .glyph_o     (glyph_o),
    .attribute_o (attribute_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .last_o      (last_o)
  );

  a_last_is_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (command_o == CMD_CURSOR))
    else $error("Final command of a character is not a cursor position.");

  a_glyph_only_on_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_o != CMD_GLYPH) |-> (glyph_o == 8'd0))
    else $error("Nonzero glyph on a command other than put glyph.");

  a_scroll_clear_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (command_o == CMD_SCROLL || command_o == CMD_CLEAR))
      |-> (pos_x_o == 8'd0 && pos_y_o == 8'd0))
    else $error("Scroll or clear command carries a nonzero position.");

endmodule

`default_nettype wire

[rtl/tcte_front.sv]
// Front part: escape parser that classifies each byte into an operation,
// followed by a two-entry operation queue. Depends on tcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcte_front import tcte_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire logic [7:0] char_i,
  input  wire logic     enable_i,
  output logic          full_o,
  output logic          op_valid_o,
  output tcte_op_t      op_o,
  input  wire logic     op_pop_i
);

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChJ     = 8'h4A;
  localparam logic [7:0] ChK     = 8'h4B;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [16:0] num_q, num_d;
  logic        seen_q, seen_d;
  logic        accept;
  logic        emit;
  tcte_op_t    new_op;
  logic [19:0] num_x10;
  logic [16:0] n_val;

  tcte_op_t    mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign accept     = push_i && !full_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = mem_q[rd_ptr_q];
  assign num_x10    = {num_q, 3'b000} + {2'b00, num_q, 1'b0} + {12'd0, char_i - ChZero};
  assign n_val      = seen_q ? num_q : 17'd1;

  always_comb begin
    phase_d    = phase_q;
    num_d      = num_q;
    seen_d     = seen_q;
    emit       = 1'b0;
    new_op.op  = OP_PUT;
    new_op.arg = {9'd0, char_i};
    if (accept && enable_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (char_i == ChEsc) begin
            phase_d = PH_ESC;
          end else begin
            emit = 1'b1;
            case (char_i)
              ChBs:    new_op.op = OP_BS;
              ChNl:    new_op.op = OP_NL;
              ChCr:    new_op.op = OP_CR;
              ChTab:   new_op.op = OP_TAB;
              default: new_op.op = OP_PUT;
            endcase
          end
        end
        PH_ESC: begin
          phase_d = (char_i == ChLbr) ? PH_CSI : PH_IDLE;
          num_d   = 17'd0;
          seen_d  = 1'b0;
        end
        default: begin
          if (char_i >= ChZero && char_i <= ChNine) begin
            seen_d = 1'b1;
            if (num_q <= NumCap) begin
              num_d = num_x10[16:0];
            end
          end else if (char_i != ChSemi) begin
            new_op.arg = n_val;
            case (char_i)
              ChD: begin
                emit      = 1'b1;
                new_op.op = OP_LEFT;
              end
              ChH: begin
                emit      = 1'b1;
                new_op.op = OP_HOME;
              end
              ChJ: begin
                emit      = (n_val == 17'd2);
                new_op.op = OP_CLEAR;
              end
              ChK: begin
                emit      = 1'b1;
                new_op.op = OP_ERASE;
              end
              default: emit = 1'b0;
            endcase
            phase_d = PH_IDLE;
            num_d   = 17'd0;
            seen_d  = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      num_q    <= 17'd0;
      seen_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      phase_q <= phase_d;
      num_q   <= num_d;
      seen_q  <= seen_d;
      if (emit) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (op_pop_i && op_valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, emit} - {1'b0, op_pop_i && op_valid_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      mem_q[wr_ptr_q] <= new_op;
    end
  end

endmodule

`default_nettype wire

[rtl/tcte_back.sv]
// Back part: cursor state, command sequencer with a bit-serial divider for
// cursor-left, and the result register. Depends on tcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcte_back import tcte_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       op_valid_i,
  input  tcte_op_t        op_i,
  output logic            op_pop_o,
  input  wire logic [7:0] cols_i,
  input  wire logic [7:0] rows_i,
  input  wire logic [7:0] attr_i,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [2:0]      command_o,
  output logic [7:0]      glyph_o,
  output logic [7:0]      attribute_o,
  output logic [7:0]      pos_x_o,
  output logic [7:0]      pos_y_o,
  output logic            last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PUT, S_SPACE, S_TAB, S_ROW, S_CUR, S_CLR, S_ERA, S_LEFT, S_DIV
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  row_q, row_d, col_q, col_d, ch_q, ch_d;
  logic [16:0] arg_q, arg_d;
  logic [8:0]  stop_q, stop_d;
  logic [7:0]  rem_q, rem_d, dlo_q, dlo_d, quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q;

  logic        out_rdy, em, em_last;
  tcte_cmd_e   em_cmd;
  logic [7:0]  em_glyph, em_x, em_y;
  logic [8:0]  col_inc, row_inc, tab_sum, trial, trial_sub;
  logic [15:0] lin, diff;
  logic [16:0] left_rem;
  logic        qbit;

  assign out_rdy   = !out_valid_q || pop_i;
  assign empty_o   = !out_valid_q;
  assign col_inc   = {1'b0, col_q} + 9'd1;
  assign row_inc   = {1'b0, row_q} + 9'd1;
  assign tab_sum   = {1'b0, col_q} + 9'd4;
  assign lin       = {8'd0, row_q} * {8'd0, cols_i};
  assign left_rem  = arg_q - {9'd0, col_q};
  assign diff      = lin - left_rem[15:0];
  assign trial     = {rem_q, dlo_q[7]};
  assign trial_sub = trial - {1'b0, cols_i};
  assign qbit      = (trial >= {1'b0, cols_i});

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    ch_d     = ch_q;
    arg_d    = arg_q;
    stop_d   = stop_q;
    rem_d    = rem_q;
    dlo_d    = dlo_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    op_pop_o = 1'b0;
    em       = 1'b0;
    em_cmd   = CMD_CURSOR;
    em_glyph = 8'd0;
    em_x     = col_q;
    em_y     = row_q;
    em_last  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          arg_d    = op_i.arg;
          ch_d     = op_i.arg[7:0];
          case (op_i.op)
            OP_PUT: state_d = S_PUT;
            OP_BS: begin
              ch_d = ChSpace;
              if (col_q != 8'd0) begin
                col_d   = col_q - 8'd1;
                state_d = S_SPACE;
              end else if (row_q != 8'd0) begin
                row_d   = row_q - 8'd1;
                col_d   = cols_i - 8'd1;
                state_d = S_SPACE;
              end else begin
                state_d = S_CUR;
              end
            end
            OP_NL: begin
              col_d   = 8'd0;
              state_d = S_ROW;
            end
            OP_CR: begin
              col_d   = 8'd0;
              state_d = S_CUR;
            end
            OP_TAB: begin
              stop_d  = {tab_sum[8:2], 2'b00};
              state_d = S_TAB;
            end
            OP_LEFT: state_d = S_LEFT;
            OP_HOME: begin
              row_d   = 8'd0;
              col_d   = 8'd0;
              state_d = S_CUR;
            end
            OP_CLEAR: begin
              row_d   = 8'd0;
              col_d   = 8'd0;
              state_d = S_CLR;
            end
            OP_ERASE: state_d = (col_q < cols_i) ? S_ERA : S_CUR;
            default:  state_d = S_CUR;
          endcase
        end
      end
      S_PUT: begin
        em       = 1'b1;
        em_cmd   = CMD_GLYPH;
        em_glyph = ch_q;
        if (out_rdy) begin
          if (col_inc >= {1'b0, cols_i}) begin
            col_d   = 8'd0;
            state_d = S_ROW;
          end else begin
            col_d   = col_inc[7:0];
            state_d = S_CUR;
          end
        end
      end
      S_SPACE: begin
        em       = 1'b1;
        em_cmd   = CMD_GLYPH;
        em_glyph = ch_q;
        if (out_rdy) begin
          state_d = S_CUR;
        end
      end
      S_TAB: begin
        em       = 1'b1;
        em_cmd   = CMD_GLYPH;
        em_glyph = ChSpace;
        if (out_rdy) begin
          if (col_inc >= {1'b0, cols_i}) begin
            col_d   = 8'd0;
            state_d = S_ROW;
          end else begin
            col_d   = col_inc[7:0];
            state_d = (col_inc < stop_q) ? S_TAB : S_CUR;
          end
        end
      end
      S_ROW: begin
        if (row_inc >= {1'b0, rows_i}) begin
          em     = 1'b1;
          em_cmd = CMD_SCROLL;
          em_x   = 8'd0;
          em_y   = 8'd0;
          if (out_rdy) begin
            row_d   = rows_i - 8'd1;
            state_d = S_CUR;
          end
        end else begin
          row_d   = row_inc[7:0];
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        em      = 1'b1;
        em_last = 1'b1;
        if (out_rdy) begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        em     = 1'b1;
        em_cmd = CMD_CLEAR;
        em_x   = 8'd0;
        em_y   = 8'd0;
        if (out_rdy) begin
          state_d = S_CUR;
        end
      end
      S_ERA: begin
        em     = 1'b1;
        em_cmd = CMD_ERASE;
        if (out_rdy) begin
          state_d = S_CUR;
        end
      end
      S_LEFT: begin
        if (arg_q <= {9'd0, col_q}) begin
          col_d   = col_q - arg_q[7:0];
          state_d = S_CUR;
        end else if (left_rem >= {1'b0, lin}) begin
          row_d   = 8'd0;
          col_d   = 8'd0;
          state_d = S_CUR;
        end else begin
          rem_d   = diff[15:8];
          dlo_d   = diff[7:0];
          cnt_d   = 3'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = qbit ? trial_sub[7:0] : trial[7:0];
        quo_d = {quo_q[6:0], qbit};
        dlo_d = {dlo_q[6:0], 1'b0};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          row_d   = {quo_q[6:0], qbit};
          col_d   = rem_d;
          state_d = S_CUR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= 8'd0;
      col_q       <= 8'd0;
      out_valid_q <= 1'b0;
      ch_q        <= 8'd0;
      arg_q       <= 17'd0;
      stop_q      <= 9'd0;
      rem_q       <= 8'd0;
      dlo_q       <= 8'd0;
      quo_q       <= 8'd0;
      cnt_q       <= 3'd0;
      command_o   <= CMD_GLYPH;
      glyph_o     <= 8'd0;
      attribute_o <= 8'd0;
      pos_x_o     <= 8'd0;
      pos_y_o     <= 8'd0;
      last_o      <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ch_q    <= ch_d;
      arg_q   <= arg_d;
      stop_q  <= stop_d;
      rem_q   <= rem_d;
      dlo_q   <= dlo_d;
      quo_q   <= quo_d;
      cnt_q   <= cnt_d;
      if (em && out_rdy) begin
        out_valid_q <= 1'b1;
        command_o   <= em_cmd;
        glyph_o     <= em_glyph;
        attribute_o <= attr_i;
        pos_x_o     <= em_x;
        pos_y_o     <= em_y;
        last_o      <= em_last;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
